/* hw/rtl/fbsc_pkg.sv */
// Package for the fractional baud setting calculator: widths, reset values,
// controller state type, controller/datapath command and status structs.
// No dependencies.
`timescale 1ns / 1ps

package fbsc_pkg;

    localparam int CLK_W     = 25;
    localparam int RATE_W    = 24;
    localparam int WORD_W    = 32;
    localparam int SEL_W     = 12;
    localparam int SCALE_W   = 4;
    localparam int LIM_W     = 21;
    localparam int N_LIM     = 14;
    localparam int DIV_CNT_W = 6;

    localparam logic [DIV_CNT_W-1:0] DIV_STEPS      = 6'd32;
    localparam logic [CLK_W-1:0]     CLOCK_HZ_RESET = 25'd32000000;

    // Configuration register indexes
    localparam logic CFG_CLOCK_HZ     = 1'b0;
    localparam logic CFG_DOUBLE_SPEED = 1'b1;

    // Lowest scale exponent (-7) as a two's complement nibble
    localparam logic [SCALE_W-1:0] SCALE_MIN = 4'b1001;
    // Scale exponent -3, last one that uses the shifted-remainder formula
    localparam logic [SCALE_W-1:0] SCALE_M3  = 4'b1101;
    // Search index used when no limit is exceeded (exponent 7)
    localparam logic [SCALE_W-1:0] IDX_LAST  = 4'd14;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV1,
        ST_SETUP2,
        ST_DIV2
    } state_t;

    typedef struct packed {
        logic load;
        logic reject;
        logic div1_start;
        logic capture_e;
        logic div2_start;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic in_range;
        logic div_done;
    } dp_status_t;

    // Quotient limit for each step of the exponent search (index 0 is exponent -7)
    function automatic logic [LIM_W-1:0] scale_limit(input logic [SCALE_W-1:0] idx);
        logic [LIM_W-1:0] lim;
        case (idx)
            4'd0:    lim = 21'h0000FF;
            4'd1:    lim = 21'h0001FF;
            4'd2:    lim = 21'h0003FF;
            4'd3:    lim = 21'h0007FF;
            4'd4:    lim = 21'h000FFF;
            4'd5:    lim = 21'h001FFE;
            4'd6:    lim = 21'h003FFC;
            4'd7:    lim = 21'h007FF8;
            4'd8:    lim = 21'h00FFF0;
            4'd9:    lim = 21'h01FFE0;
            4'd10:   lim = 21'h03FFC0;
            4'd11:   lim = 21'h07FF80;
            4'd12:   lim = 21'h0FFF00;
            4'd13:   lim = 21'h1FFE00;
            default: lim = 21'h1FFFFF;
        endcase
        return lim;
    endfunction

endpackage

/* hw/rtl/fbsc_div.sv */
// Serial restoring divider, one quotient bit per cycle, 32-bit unsigned.
// Depends on fbsc_pkg. A zero divisor gives a quotient of zero.
`timescale 1ns / 1ps

module fbsc_div
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [fbsc_pkg::WORD_W-1:0] dividend,
    input  logic [fbsc_pkg::WORD_W-1:0] divisor,
    output logic                      done,
    output logic [fbsc_pkg::WORD_W-1:0] quotient
);
    import fbsc_pkg::*;

    logic [WORD_W-1:0]    dvd_reg, dvd_next;
    logic [WORD_W-1:0]    rem_reg, rem_next;
    logic [WORD_W-1:0]    dsr_reg, dsr_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 run_reg, run_next;
    logic                 done_reg, done_next;
    logic                 zero_reg, zero_next;
    logic [WORD_W:0]      partial;
    logic [WORD_W:0]      diff;

    always_comb
    begin
        partial   = {rem_reg, dvd_reg[WORD_W-1]};
        diff      = partial - {1'b0, dsr_reg};
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        zero_next = zero_reg;
        done_next = 1'b0;
        if (start)
        begin
            dvd_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = DIV_STEPS;
            run_next  = 1'b1;
            zero_next = (divisor == '0);
        end
        else if (run_reg)
        begin
            // keep the trial difference when the partial remainder covers the divisor
            if (!diff[WORD_W])
            begin
                rem_next = diff[WORD_W-1:0];
                dvd_next = {dvd_reg[WORD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = partial[WORD_W-1:0];
                dvd_next = {dvd_reg[WORD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == 6'd1)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
        zero_reg <= zero_next;
    end

    assign done     = done_reg;
    assign quotient = zero_reg ? '0 : dvd_reg;

endmodule

/* hw/rtl/fbsc_dp.sv */
// Datapath: rate latch, range check, exponent search, divider operands,
// result registers. Depends on fbsc_pkg and fbsc_div.
`timescale 1ns / 1ps

module fbsc_dp
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  fbsc_pkg::dp_cmd_t             cmd,
    output fbsc_pkg::dp_status_t          status,
    input  logic [fbsc_pkg::RATE_W-1:0]   baud_rate,
    input  logic [fbsc_pkg::CLK_W-1:0]    clock_hz,
    input  logic                          double_speed,
    output logic                          done,
    output logic                          accepted,
    output logic [fbsc_pkg::SCALE_W-1:0]  scale,
    output logic [fbsc_pkg::SEL_W-1:0]    select_value,
    output logic [7:0]                    ctrl_low_byte,
    output logic [7:0]                    ctrl_high_byte
);
    import fbsc_pkg::*;

    logic [RATE_W-1:0]  rate_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic               done_reg;
    logic               accepted_reg;
    logic [SCALE_W-1:0] scale_out_reg;
    logic [SEL_W-1:0]   select_reg;

    logic [CLK_W-1:0]   hi_lim, lo_lim;
    logic [CLK_W-1:0]   rate_wide;
    logic               in_range;
    logic [WORD_W-1:0]  rate2;
    logic [WORD_W-1:0]  clk32;
    logic [SCALE_W-1:0] idx;
    logic [SCALE_W-1:0] sh_c, sh_d;
    logic [WORD_W-1:0]  c_val, d_val;
    logic [WORD_W-1:0]  dvd2, dsr2;
    logic [WORD_W-1:0]  div_dividend, div_divisor;
    logic [WORD_W-1:0]  quo;
    logic [WORD_W-1:0]  sel;
    logic               div_done;

    // Range limits: clock/8 and clock/2^22, halved again in normal mode
    always_comb
    begin
        rate_wide = {1'b0, rate_reg};
        if (double_speed)
        begin
            hi_lim = clock_hz >> 3;
            lo_lim = clock_hz >> 22;
        end
        else
        begin
            hi_lim = clock_hz >> 4;
            lo_lim = clock_hz >> 23;
        end
        in_range = (rate_reg != '0) && (rate_wide <= hi_lim) && (rate_wide >= lo_lim);
        rate2 = double_speed ? WORD_W'(rate_reg) : WORD_W'({rate_reg, 1'b0});
        clk32 = WORD_W'(clock_hz);
    end

    // Exponent search: first limit that the quotient stays below
    always_comb
    begin
        idx = IDX_LAST;
        for (int i = N_LIM - 1; i >= 0; i--)
        begin
            if (quo < WORD_W'(scale_limit(SCALE_W'(i))))
            begin
                idx = SCALE_W'(i);
            end
        end
    end

    // Operands of the second division
    always_comb
    begin
        sh_c  = SCALE_M3 - scale_reg;
        sh_d  = scale_reg + 4'd3;
        c_val = clk32 - (rate2 << 3);
        d_val = rate2 << sh_d;
        if (scale_reg[SCALE_W-1] && (scale_reg <= SCALE_M3))
        begin
            dvd2 = (c_val << sh_c) + (rate2 >> 1);
            dsr2 = rate2;
        end
        else if (scale_reg[SCALE_W-1])
        begin
            dvd2 = c_val + (d_val >> 1);
            dsr2 = d_val;
        end
        else
        begin
            dvd2 = clk32 + (d_val >> 1);
            dsr2 = d_val;
        end
        div_dividend = cmd.div1_start ? clk32 : dvd2;
        div_divisor  = cmd.div1_start ? rate2 : dsr2;
        sel          = scale_reg[SCALE_W-1] ? quo : quo - 1'b1;
    end

    fbsc_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div1_start | cmd.div2_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (quo)
    );

    assign status = '{in_range: in_range, div_done: div_done};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rate_reg <= baud_rate;
        end
        if (cmd.capture_e)
        begin
            scale_reg <= idx + SCALE_MIN;
        end
        if (cmd.reject)
        begin
            accepted_reg  <= 1'b0;
            scale_out_reg <= '0;
            select_reg    <= '0;
        end
        else if (cmd.finish)
        begin
            accepted_reg  <= 1'b1;
            scale_out_reg <= scale_reg;
            select_reg    <= sel[SEL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.reject | cmd.finish;
        end
    end

    assign done           = done_reg;
    assign accepted       = accepted_reg;
    assign scale          = scale_out_reg;
    assign select_value   = select_reg;
    assign ctrl_low_byte  = select_reg[7:0];
    assign ctrl_high_byte = {scale_out_reg, select_reg[SEL_W-1:8]};

endmodule

/* hw/rtl/fbsc_ctrl.sv */
// Controller state machine: sequences range check, two divisions and the
// exponent capture. Depends on fbsc_pkg.
`timescale 1ns / 1ps

module fbsc_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  fbsc_pkg::dp_status_t status,
    output fbsc_pkg::dp_cmd_t    cmd
);
    import fbsc_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.in_range)
                begin
                    cmd.div1_start = 1'b1;
                    state_next     = ST_DIV1;
                end
                else
                begin
                    cmd.reject = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_DIV1:
            begin
                if (status.div_done)
                begin
                    cmd.capture_e = 1'b1;
                    state_next    = ST_SETUP2;
                end
            end
            ST_SETUP2:
            begin
                cmd.div2_start = 1'b1;
                state_next     = ST_DIV2;
            end
            ST_DIV2:
            begin
                if (status.div_done)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/fractional_baud_setting_calc.sv */
// Done follows the start transfer after the range check for a rejected rate (zero or
//   out of range), and after two 32-step passes through the serial divider plus the
//   control states for an accepted one. A new request is taken only once the last is
//   done; busy drops with the done cycle.
// The receiver cannot stall: each result is valid for exactly the done cycle.
// Reset (rst_n low, asynchronous): idle, clock_hz = 32000000, double_speed = 0.
`timescale 1ns / 1ps

module fractional_baud_setting_calc
(
    input  logic                         clk,
    input  logic                         rst_n,
    // command side
    input  logic                         start,
    output logic                         busy,
    input  logic [fbsc_pkg::RATE_W-1:0]  baud_rate,
    // configuration write channel
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic                         cfg_index,
    input  logic [fbsc_pkg::CLK_W-1:0]   cfg_data,
    // result side
    output logic                         done,
    output logic                         accepted,
    output logic signed [fbsc_pkg::SCALE_W-1:0] scale,
    output logic [fbsc_pkg::SEL_W-1:0]   select_value,
    output logic [7:0]                   ctrl_low_byte,
    output logic [7:0]                   ctrl_high_byte
);
    import fbsc_pkg::*;

    // Configuration registers; the user must write them only while the block is idle (not enforced)
    logic [CLK_W-1:0]   clock_hz_reg, clock_hz_next;
    logic               double_speed_reg, double_speed_next;

    dp_cmd_t            cmd;
    dp_status_t         status;
    logic [SCALE_W-1:0] scale_bits;

    // The write channel is always ready: every transfer is written at the edge that takes it
    assign cfg_ready = 1'b1;

    always_comb
    begin
        clock_hz_next     = clock_hz_reg;
        double_speed_next = double_speed_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_CLOCK_HZ:
                begin
                    clock_hz_next = cfg_data;
                end
                CFG_DOUBLE_SPEED:
                begin
                    double_speed_next = cfg_data[0];
                end
                default:
                begin
                    clock_hz_next = clock_hz_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_hz_reg     <= CLOCK_HZ_RESET;
            double_speed_reg <= 1'b0;
        end
        else
        begin
            clock_hz_reg     <= clock_hz_next;
            double_speed_reg <= double_speed_next;
        end
    end

    // Controller: accept, check range, run both divisions, hand the result out
    fbsc_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    // Datapath: limits, exponent search, divider and result registers
    fbsc_dp u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .baud_rate      (baud_rate),
        .clock_hz       (clock_hz_reg),
        .double_speed   (double_speed_reg),
        .done           (done),
        .accepted       (accepted),
        .scale          (scale_bits),
        .select_value   (select_value),
        .ctrl_low_byte  (ctrl_low_byte),
        .ctrl_high_byte (ctrl_high_byte)
    );

    // Present the exponent as a signed nibble
    assign scale = $signed(scale_bits);

endmodule

/* hw/rtl/fbsc_chk.sv */
// Port-level checker for fractional_baud_setting_calc, attached by bind.
// Depends on the top level's port list only.
`timescale 1ns / 1ps

module fbsc_chk
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic        accepted,
    input logic [3:0]  scale,
    input logic [11:0] select_value,
    input logic [7:0]  ctrl_low_byte,
    input logic [7:0]  ctrl_high_byte
);

    // A start transfer always turns the block busy
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("start transfer did not raise busy");

    // Busy drops exactly when the result appears
    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy fell without a result");

    // One strobe per item
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe lasted more than one cycle");

    // A rejected rate carries an all-zero setting
    a_reject: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !accepted) |-> (scale == 4'd0 && select_value == 12'd0 &&
                                 ctrl_low_byte == 8'd0 && ctrl_high_byte == 8'd0))
        else $error("rejected result has nonzero fields");

    // Register bytes are packed from scale and select
    a_pack: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (ctrl_low_byte == select_value[7:0] &&
                  ctrl_high_byte == {scale, select_value[11:8]}))
        else $error("control bytes do not match scale and select");

endmodule

bind fractional_baud_setting_calc fbsc_chk u_fbsc_chk (.*);

/* tb/tb.sv */
// Self-checking bench for fractional_baud_setting_calc: random and edge-case baud
// requests across several clock settings, each result checked against a local model.
// Depends on fbsc_pkg and the fractional_baud_setting_calc RTL.
`timescale 1ns / 1ps

module tb;

    import fbsc_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int N_PHASES    = 10;

    // One result as it appears on the result ports
    typedef struct packed {
        logic               accepted;
        logic [SCALE_W-1:0] scale;
        logic [SEL_W-1:0]   select_value;
        logic [7:0]         ctrl_low_byte;
        logic [7:0]         ctrl_high_byte;
    } setting_t;

    // Expected result plus the request that caused it, for reporting
    typedef struct packed {
        logic [RATE_W-1:0] rate;
        logic [CLK_W-1:0]  hz;
        logic              dbl;
        setting_t          want;
    } setting_check_t;

    logic                      clk;
    logic                      rst_n     = 1'b0;
    logic                      start     = 1'b0;
    logic                      busy;
    logic [RATE_W-1:0]         baud_rate = '0;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic                      cfg_index = CFG_CLOCK_HZ;
    logic [CLK_W-1:0]          cfg_data  = '0;
    logic                      done;
    logic                      accepted;
    logic signed [SCALE_W-1:0] scale;
    logic [SEL_W-1:0]          select_value;
    logic [7:0]                ctrl_low_byte;
    logic [7:0]                ctrl_high_byte;

    // Local copy of the two configuration registers, updated on each write transfer
    logic [CLK_W-1:0] model_clock_hz = CLOCK_HZ_RESET;
    logic             model_double   = 1'b0;

    logic [RATE_W-1:0] rate_q [$];     // requests waiting for the driver
    setting_check_t    setting_q [$];  // settings expected from the block, oldest first

    int n_queued  = 0;   // requests handed to the driver so far
    int n_sent    = 0;   // start transfers
    int n_got     = 0;   // done strobes seen
    int n_bursts  = 0;
    int n_errors  = 0;
    int n_set_up  = 0;
    int n_refused = 0;
    int n_cycles  = 0;
    logic [15:0] scale_seen = '0;

    int   gap_left   = 0;
    int   burst_left = 0;
    logic hold_drain = 1'b0;

    setting_t       got_setting;
    setting_check_t oldest;

    fractional_baud_setting_calc u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .baud_rate      (baud_rate),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .done           (done),
        .accepted       (accepted),
        .scale          (scale),
        .select_value   (select_value),
        .ctrl_low_byte  (ctrl_low_byte),
        .ctrl_high_byte (ctrl_high_byte)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Work out the BSEL/BSCALE setting for one requested rate. All arithmetic is
    // 32-bit unsigned and wraps, as the block's datapath does.
    function automatic setting_t baud_setting(input logic [RATE_W-1:0] rate_in,
                                              input logic [CLK_W-1:0]  hz,
                                              input logic              dbl);
        logic [WORD_W-1:0] fclk;
        logic [WORD_W-1:0] rate;
        logic [WORD_W-1:0] top;
        logic [WORD_W-1:0] bottom;
        logic [WORD_W-1:0] lim;
        logic [WORD_W-1:0] quot;
        logic [WORD_W-1:0] rem;
        logic [WORD_W-1:0] div;
        logic [WORD_W-1:0] sel;
        int                e;
        setting_t          s;
        s      = '0;
        fclk   = WORD_W'(hz);
        rate   = WORD_W'(rate_in);
        top    = fclk / 8;
        bottom = fclk / 4194304;
        // normal mode oversamples 16x, so both limits halve
        if (!dbl)
        begin
            top    = top / 2;
            bottom = bottom / 2;
        end
        if (rate == 0 || rate > top || rate < bottom)
            return s;
        if (!dbl)
            rate = rate * 2;
        quot = fclk / rate;
        // smallest exponent whose limit lies above the quotient; 7 if none does
        lim = 32'hFF;
        e   = -7;
        while (e < 7 && quot >= lim)
        begin
            lim = lim << 1;
            if (e < -3)
                lim[0] = 1'b1;
            e++;
        end
        if (e < 0)
        begin
            rem = fclk - 8 * rate;
            if (e <= -3)
            begin
                div = rate;
                sel = (rem << (-e - 3)) + rate / 2;
            end
            else
            begin
                div = rate << (e + 3);
                sel = rem + div / 2;
            end
            sel = (div != 0) ? sel / div : '0;
        end
        else
        begin
            div = rate << (e + 3);
            sel = ((div != 0) ? (fclk + div / 2) / div : '0) - 1;
        end
        s.accepted       = 1'b1;
        s.scale          = e[SCALE_W-1:0];
        s.select_value   = sel[SEL_W-1:0];
        s.ctrl_low_byte  = sel[7:0];
        s.ctrl_high_byte = {e[SCALE_W-1:0], sel[11:8]};
        return s;
    endfunction

    // Driver: present requests in bursts of random length with random gaps. The
    // request stays on the ports until busy is low at an edge (the start transfer);
    // the expected setting is worked out at that edge from the current registers.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start      <= 1'b0;
            gap_left   <= 0;
            burst_left <= 0;
            hold_drain <= 1'b0;
        end
        else if (start && !busy)
        begin
            setting_q.push_back({baud_rate, model_clock_hz, model_double,
                                 baud_setting(baud_rate, model_clock_hz, model_double)});
            n_sent <= n_sent + 1;
            if (burst_left > 0 && rate_q.size() > 0)
            begin
                // keep start high and advance straight to the next request
                baud_rate  <= rate_q.pop_front();
                burst_left <= burst_left - 1;
            end
            else
            begin
                // end of burst: drop start, pick a gap, and now and then hold the
                // next burst until every outstanding result has come back
                start      <= 1'b0;
                n_bursts   <= n_bursts + 1;
                hold_drain <= (n_bursts == 2) || ($urandom_range(0, 7) == 0);
                case ($urandom_range(0, 3))
                    0:       gap_left <= 0;
                    1:       gap_left <= $urandom_range(1, 3);
                    2:       gap_left <= $urandom_range(4, 30);
                    default: gap_left <= $urandom_range(31, 90);
                endcase
            end
        end
        else if (!start)
        begin
            if (gap_left > 0)
                gap_left <= gap_left - 1;
            else if (rate_q.size() > 0 && !(hold_drain && n_sent != n_got))
            begin
                start      <= 1'b1;
                baud_rate  <= rate_q.pop_front();
                burst_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40)
                                                          : $urandom_range(0, 5);
            end
        end
    end

    // Monitor: each done strobe carries one result, taken at the edge that ends it.
    // Compare it with the oldest expected setting.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            got_setting = {accepted, scale, select_value, ctrl_low_byte, ctrl_high_byte};
            n_got <= n_got + 1;
            if (setting_q.size() == 0)
            begin
                n_errors++;
                if (n_errors <= 10)
                    $display("[%0t] result with nothing expected: acc=%0b scale=%0d sel=%03h",
                             $realtime, accepted, scale, select_value);
            end
            else
            begin
                oldest = setting_q.pop_front();
                if (got_setting !== oldest.want)
                begin
                    n_errors++;
                    if (n_errors <= 10)
                    begin
                        $display("[%0t] mismatch: rate=%0d clock_hz=%0d double=%0b",
                                 $realtime, oldest.rate, oldest.hz, oldest.dbl);
                        $display("    expected acc=%0b scale=%0d sel=%03h lo=%02h hi=%02h",
                                 oldest.want.accepted, $signed(oldest.want.scale),
                                 oldest.want.select_value, oldest.want.ctrl_low_byte,
                                 oldest.want.ctrl_high_byte);
                        $display("    actual   acc=%0b scale=%0d sel=%03h lo=%02h hi=%02h",
                                 accepted, scale, select_value, ctrl_low_byte,
                                 ctrl_high_byte);
                    end
                end
            end
            if (accepted === 1'b1)
            begin
                n_set_up++;
                scale_seen[scale[SCALE_W-1:0]] = 1'b1;
            end
            else
                n_refused++;
        end
    end

    // Watchdog: a lost result or a stuck handshake ends the run here
    always @(posedge clk)
    begin
        n_cycles <= n_cycles + 1;
        if (n_cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d of %0d results seen",
                     n_cycles, n_got, n_queued);
            $display("TB_ERROR");
            $finish;
        end
    end

    // Stimulus: reset, then a series of clock settings. Between settings, wait
    // until every expected result is back before writing the registers.
    initial
    begin
        logic [CLK_W-1:0]  hz;
        logic              dbl;
        logic [RATE_W-1:0] r;
        logic [RATE_W-1:0] directed [$];
        logic [WORD_W-1:0] top;
        logic [WORD_W-1:0] bottom;
        int                n_rand;
        int                sh;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Under the reset clock (32 MHz, normal mode) the range is 3..2000000:
        // zero, both edges and one past them, the slowest rates that exhaust the
        // exponent search, common rates over the whole exponent span, full-width codes
        directed = '{24'd0, 24'd1, 24'd2, 24'd3, 24'd4, 24'd7, 24'd8, 24'd300, 24'd1200,
                     24'd9600, 24'd19200, 24'd57600, 24'd115200, 24'd230400, 24'd921600,
                     24'd1000000, 24'd1999999, 24'd2000000, 24'd2000001, 24'hFFFFFF,
                     24'h800000, 24'h555555, 24'h2AAAAA};

        for (int p = 0; p < N_PHASES; p++)
        begin
            if (p != 0)
            begin
                // every request causes a result, so idle means all results back
                while (n_got < n_queued) @(posedge clk);
                repeat (4) @(posedge clk);
                case (p)
                    1:       begin hz = '1;    dbl = 1'b1; end
                    2:       begin hz = '1;    dbl = 1'b0; end
                    3:       begin hz = 25'd1; dbl = 1'b1; end
                    4:       begin hz = '0;    dbl = 1'b0; end
                    5:       begin hz = CLK_W'($urandom_range(1, 33554431)); dbl = 1'b1; end
                    6:       begin hz = CLK_W'($urandom_range(1, 33554431)); dbl = 1'b0; end
                    7:       begin hz = 25'd8000000; dbl = 1'b1; end
                    8:       begin hz = CLK_W'($urandom_range(16, 200000)); dbl = 1'b1; end
                    default: begin hz = CLOCK_HZ_RESET; dbl = 1'b0; end
                endcase
                // write both registers back to back; hold valid across the pair
                for (int k = 0; k < 2; k++)
                begin
                    if (k == 0)
                    begin
                        cfg_valid <= 1'b1;
                        cfg_index <= CFG_CLOCK_HZ;
                        cfg_data  <= hz;
                    end
                    else
                    begin
                        cfg_index <= CFG_DOUBLE_SPEED;
                        cfg_data  <= {{(CLK_W-1){1'b0}}, dbl};
                    end
                    do @(posedge clk); while (!cfg_ready);
                    if (cfg_index == CFG_CLOCK_HZ)
                        model_clock_hz = cfg_data;
                    else
                        model_double = cfg_data[0];
                end
                cfg_valid <= 1'b0;
            end

            top    = WORD_W'(model_clock_hz) / 8;
            bottom = WORD_W'(model_clock_hz) / 4194304;
            if (!model_double)
            begin
                top    = top / 2;
                bottom = bottom / 2;
            end
            // clocks this slow accept no rate above 1, so spend few requests on them
            n_rand = (model_clock_hz < 16) ? 40 : 170;

            @(negedge clk);
            if (p == 0)
                foreach (directed[i])
                begin
                    rate_q.push_back(directed[i]);
                    n_queued++;
                end
            for (int i = 0; i < n_rand; i++)
            begin
                case ($urandom_range(0, 15))
                    0:       r = '0;
                    1:       r = RATE_W'(bottom + $urandom_range(0, 2) - 1);
                    2:       r = RATE_W'(top + $urandom_range(0, 2) - 1);
                    3, 4:    r = RATE_W'($urandom);
                    default:
                    begin
                        // spread over magnitudes so every exponent gets exercised
                        sh = $urandom_range(0, 23);
                        r  = RATE_W'($urandom >> (8 + sh));
                        if (r < bottom || r > top)
                            r = RATE_W'($urandom_range(bottom, top));
                    end
                endcase
                rate_q.push_back(r);
                n_queued++;
            end
        end

        while (n_got < n_queued) @(posedge clk);
        // allow the longest accepted computation to show any stray result
        repeat (80) @(posedge clk);

        $display("covered %0d requests over %0d register settings: %0d set up, %0d refused",
                 n_queued, N_PHASES, n_set_up, n_refused);
        $display("scale codes reached (one bit per nibble value): %04h", scale_seen);
        if (n_errors == 0 && setting_q.size() == 0)
            $display("TB_OK");
        else
        begin
            $display("%0d mismatches, %0d expected results never arrived",
                     n_errors, setting_q.size());
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/fbsc_pkg.sv
hw/rtl/fbsc_div.sv
hw/rtl/fbsc_dp.sv
hw/rtl/fbsc_ctrl.sv
hw/rtl/fractional_baud_setting_calc.sv
hw/rtl/fbsc_chk.sv
tb/tb.sv
